// File: sv/assert_macros.svh
// Assertion helpers included by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// File: sv/nwr_pkg.sv
`default_nettype none

package nwr_pkg;

    // Fixed field widths.
    localparam int COORD_BITS     = 16;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int DIST_BITS      = SQ_BITS + 1;
    localparam int RADIUS_BITS    = 16;
    localparam int COUNT_BITS     = 7;
    localparam int INDEX_BITS     = 6;
    localparam int LABEL_IN_BITS  = 8;
    localparam int LABEL_EXT_BITS = 16;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 16;

    // Parameter defaults.
    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_LABEL_BITS = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_RADIUS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRY_COUNT  = 1'b1;

    // Input word actions.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Scan sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_scan_state;

    // Squared distance leaving the distance pipeline.
    typedef struct packed {
        logic                 valid;
        logic [DIST_BITS-1:0] d2;
    } t_dist;

endpackage

`default_nettype wire

// File: sv/nwr_mem.sv
`default_nettype none

module nwr_mem #(
    parameter int ENTRIES    = nwr_pkg::DEF_ENTRIES,
    parameter int LABEL_BITS = nwr_pkg::DEF_LABEL_BITS,
    parameter int AW         = $clog2(ENTRIES)
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_we,
    input  wire  [AW-1:0]                        i_waddr,
    input  wire  signed [nwr_pkg::COORD_BITS-1:0] i_wx,
    input  wire  signed [nwr_pkg::COORD_BITS-1:0] i_wy,
    input  wire  [LABEL_BITS-1:0]                i_wlabel,
    input  wire                                  i_re,
    input  wire  [AW-1:0]                        i_raddr,
    output logic                                 o_rvalid,
    output logic signed [nwr_pkg::COORD_BITS-1:0] o_rx,
    output logic signed [nwr_pkg::COORD_BITS-1:0] o_ry,
    output logic [LABEL_BITS-1:0]                o_rlabel
);

    localparam int CB = nwr_pkg::COORD_BITS;
    localparam int WW = 2 * CB + LABEL_BITS;

    logic [WW-1:0] r_mem [ENTRIES];
    logic [WW-1:0] r_rdata;
    logic          r_rvalid;

    // Write port: one waypoint word per load.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wx, i_wy, i_wlabel};
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= i_re;
        end
    end

    assign o_rvalid = r_rvalid;
    assign o_rx     = $signed(r_rdata[WW-1 -: CB]);
    assign o_ry     = $signed(r_rdata[WW-CB-1 -: CB]);
    assign o_rlabel = r_rdata[LABEL_BITS-1:0];

endmodule

`default_nettype wire

// File: sv/nwr_dist.sv
`default_nettype none

module nwr_dist #(
    parameter int LABEL_BITS = nwr_pkg::DEF_LABEL_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    input  wire  signed [nwr_pkg::COORD_BITS-1:0] i_x,
    input  wire  signed [nwr_pkg::COORD_BITS-1:0] i_y,
    input  wire  [LABEL_BITS-1:0]                 i_label,
    input  wire  signed [nwr_pkg::COORD_BITS-1:0] i_qx,
    input  wire  signed [nwr_pkg::COORD_BITS-1:0] i_qy,
    output nwr_pkg::t_dist                        o_dist,
    output logic [LABEL_BITS-1:0]                 o_label
);

    localparam int CB = nwr_pkg::COORD_BITS;
    localparam int DB = nwr_pkg::DIFF_BITS;
    localparam int SB = nwr_pkg::SQ_BITS;

    logic [DB-1:0] dx;
    logic [DB-1:0] dy;
    logic [DB-1:0] ndx;
    logic [DB-1:0] ndy;
    logic [CB-1:0] n_ax;
    logic [CB-1:0] n_ay;

    logic [CB-1:0]         r_ax;
    logic [CB-1:0]         r_ay;
    logic                  r_v1;
    logic [LABEL_BITS-1:0] r_l1;
    logic [SB-1:0]         r_sx;
    logic [SB-1:0]         r_sy;
    logic                  r_v2;
    logic [LABEL_BITS-1:0] r_l2;

    // Absolute coordinate differences; the magnitude always fits in 16 bits.
    always_comb begin
        dx   = {i_x[CB-1], i_x} - {i_qx[CB-1], i_qx};
        dy   = {i_y[CB-1], i_y} - {i_qy[CB-1], i_qy};
        ndx  = DB'(0) - dx;
        ndy  = DB'(0) - dy;
        n_ax = dx[DB-1] ? ndx[CB-1:0] : dx[CB-1:0];
        n_ay = dy[DB-1] ? ndy[CB-1:0] : dy[CB-1:0];
    end

    // Stage one: differences, stage two: squares.
    always_ff @(posedge i_clk) begin
        r_ax <= n_ax;
        r_ay <= n_ay;
        r_l1 <= i_label;
        r_sx <= r_ax * r_ax;
        r_sy <= r_ay * r_ay;
        r_l2 <= r_l1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // The sum of squares goes straight to the comparator.
    assign o_dist.valid = r_v2;
    assign o_dist.d2    = {1'b0, r_sx} + {1'b0, r_sy};
    assign o_label      = r_l2;

endmodule

`default_nettype wire

// File: sv/nwr_scan.sv
`default_nettype none

module nwr_scan #(
    parameter int ENTRIES    = nwr_pkg::DEF_ENTRIES,
    parameter int LABEL_BITS = nwr_pkg::DEF_LABEL_BITS,
    parameter int AW         = $clog2(ENTRIES)
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_valid,
    input  wire                                    i_action,
    input  wire  signed [nwr_pkg::COORD_BITS-1:0]  i_pos_x,
    input  wire  signed [nwr_pkg::COORD_BITS-1:0]  i_pos_y,
    input  wire  [nwr_pkg::COUNT_BITS-1:0]         i_entry_count,
    input  wire  [nwr_pkg::SQ_BITS-1:0]            i_radius_sq,
    input  nwr_pkg::t_dist                         i_dist,
    input  wire  [LABEL_BITS-1:0]                  i_dist_label,
    input  wire                                    i_out_stall,
    output logic                                   o_stall,
    output logic                                   o_rd_en,
    output logic [AW-1:0]                          o_rd_addr,
    output logic signed [nwr_pkg::COORD_BITS-1:0]  o_qx,
    output logic signed [nwr_pkg::COORD_BITS-1:0]  o_qy,
    output logic                                   o_out_valid,
    output logic                                   o_found,
    output logic [nwr_pkg::LABEL_IN_BITS-1:0]      o_label
);

    localparam int NW = (nwr_pkg::COUNT_BITS > $clog2(ENTRIES + 1)) ?
                        nwr_pkg::COUNT_BITS : $clog2(ENTRIES + 1);
    localparam int DB = nwr_pkg::DIST_BITS;

    nwr_pkg::t_scan_state r_state;
    nwr_pkg::t_scan_state n_state;

    logic [NW-1:0]         r_addr;
    logic [NW-1:0]         r_n;
    logic [NW-1:0]         r_cmp;
    logic [NW-1:0]         count_ext;
    logic [NW-1:0]         count_sat;
    logic                  r_have;
    logic [DB-1:0]         r_best;
    logic [LABEL_BITS-1:0] r_best_label;
    logic                  r_out_valid;
    logic                  r_found;
    logic [nwr_pkg::LABEL_IN_BITS-1:0] r_label;

    logic                  start;
    logic                  issue_left;
    logic                  load_out;
    logic                  better;
    logic                  in_radius;
    logic [nwr_pkg::LABEL_EXT_BITS-1:0] best_ext;

    // The scan never runs past the table.
    always_comb begin
        count_ext = NW'(i_entry_count);
        count_sat = (count_ext > NW'(ENTRIES)) ? NW'(ENTRIES) : count_ext;
    end

    assign start      = i_valid && !o_stall && (i_action == nwr_pkg::ACT_QUERY);
    assign issue_left = r_addr < r_n;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            nwr_pkg::S_IDLE:  if (start) n_state = nwr_pkg::S_SCAN;
            nwr_pkg::S_SCAN:  if (!issue_left) n_state = nwr_pkg::S_DRAIN;
            nwr_pkg::S_DRAIN: if (r_cmp == r_n) n_state = nwr_pkg::S_DONE;
            nwr_pkg::S_DONE:  if (load_out) n_state = nwr_pkg::S_IDLE;
            default:          n_state = nwr_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_stall  = 1'b1;
        o_rd_en  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            nwr_pkg::S_IDLE: o_stall = 1'b0;
            nwr_pkg::S_SCAN: o_rd_en = issue_left;
            nwr_pkg::S_DONE: load_out = !r_out_valid || !i_out_stall;
            default:         o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nwr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Read address and compare counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_n    <= '0;
            r_cmp  <= '0;
        end else if (start) begin
            r_addr <= '0;
            r_n    <= count_sat;
            r_cmp  <= '0;
        end else begin
            if (o_rd_en) r_addr <= r_addr + NW'(1);
            if (i_dist.valid) r_cmp <= r_cmp + NW'(1);
        end
    end

    assign o_rd_addr = r_addr[AW-1:0];

    // Query position stays put for the whole scan.
    always_ff @(posedge i_clk) begin
        if (start) begin
            o_qx <= i_pos_x;
            o_qy <= i_pos_y;
        end
    end

    // Running minimum; a strict compare keeps the earliest entry on a tie.
    assign better = !r_have || (i_dist.d2 < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (start) begin
            r_have <= 1'b0;
        end else if (i_dist.valid) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dist.valid && better) begin
            r_best       <= i_dist.d2;
            r_best_label <= i_dist_label;
        end
    end

    // Final radius check and output register.
    assign in_radius = r_have && (r_best <= {1'b0, i_radius_sq});
    assign best_ext  = nwr_pkg::LABEL_EXT_BITS'(r_best_label);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_found <= in_radius;
            r_label <= in_radius ? best_ext[nwr_pkg::LABEL_IN_BITS-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_label     = r_label;

endmodule

`default_nettype wire

// File: sv/nearest_waypoint_within_radius_core.sv
// Nearest waypoint search over a table held in one synchronous memory; a load
// word produces no result and leaves the block ready for the next word.
// A query over N = min(entry_count, ENTRIES) entries reads one entry per cycle and
// has its result registered once all N distance words are compared and a stalled
// earlier result has left; only then is the next word taken.
// Active-low synchronous reset clears config, counters, state and valid flags only.
`default_nettype none

`include "assert_macros.svh"

module nearest_waypoint_within_radius_core #(
    parameter int ENTRIES    = nwr_pkg::DEF_ENTRIES,
    parameter int LABEL_BITS = nwr_pkg::DEF_LABEL_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [nwr_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire  [nwr_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire                                   i_action,
    input  wire  [nwr_pkg::INDEX_BITS-1:0]        i_entry_index,
    input  wire  [nwr_pkg::LABEL_IN_BITS-1:0]     i_entry_label,
    input  wire  signed [nwr_pkg::COORD_BITS-1:0] i_pos_x,
    input  wire  signed [nwr_pkg::COORD_BITS-1:0] i_pos_y,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic                                  o_found,
    output logic [nwr_pkg::LABEL_IN_BITS-1:0]     o_waypoint_label
);

    localparam int AW = $clog2(ENTRIES);
    localparam int IW = ((AW > nwr_pkg::INDEX_BITS) ? AW : nwr_pkg::INDEX_BITS) + 1;

    logic [nwr_pkg::RADIUS_BITS-1:0] r_match_radius;
    logic [nwr_pkg::COUNT_BITS-1:0]  r_entry_count;
    logic [nwr_pkg::SQ_BITS-1:0]     r_radius_sq;

    logic                                  wr_en;
    logic                                  in_range;
    logic [nwr_pkg::LABEL_EXT_BITS-1:0]    label_ext;
    logic                                  rd_en;
    logic [AW-1:0]                         rd_addr;
    logic                                  rd_valid;
    logic signed [nwr_pkg::COORD_BITS-1:0] rd_x;
    logic signed [nwr_pkg::COORD_BITS-1:0] rd_y;
    logic [LABEL_BITS-1:0]                 rd_label;
    logic signed [nwr_pkg::COORD_BITS-1:0] q_x;
    logic signed [nwr_pkg::COORD_BITS-1:0] q_y;
    nwr_pkg::t_dist                        dist_word;
    logic [LABEL_BITS-1:0]                 dist_label;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_radius <= '0;
            r_entry_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nwr_pkg::CFG_MATCH_RADIUS: r_match_radius <= i_cfg_data;
                nwr_pkg::CFG_ENTRY_COUNT:
                    r_entry_count <= i_cfg_data[nwr_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Squared radius for the final compare.
    always_ff @(posedge i_clk) begin
        r_radius_sq <= r_match_radius * r_match_radius;
    end

    // Loads outside the table are dropped.
    assign in_range  = IW'(i_entry_index) < IW'(ENTRIES);
    assign wr_en     = i_valid && !o_stall && (i_action == nwr_pkg::ACT_LOAD) && in_range;
    assign label_ext = nwr_pkg::LABEL_EXT_BITS'(i_entry_label);

    nwr_mem #(
        .ENTRIES    (ENTRIES),
        .LABEL_BITS (LABEL_BITS),
        .AW         (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (wr_en),
        .i_waddr  (AW'(i_entry_index)),
        .i_wx     (i_pos_x),
        .i_wy     (i_pos_y),
        .i_wlabel (label_ext[LABEL_BITS-1:0]),
        .i_re     (rd_en),
        .i_raddr  (rd_addr),
        .o_rvalid (rd_valid),
        .o_rx     (rd_x),
        .o_ry     (rd_y),
        .o_rlabel (rd_label)
    );

    nwr_dist #(
        .LABEL_BITS (LABEL_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rd_valid),
        .i_x     (rd_x),
        .i_y     (rd_y),
        .i_label (rd_label),
        .i_qx    (q_x),
        .i_qy    (q_y),
        .o_dist  (dist_word),
        .o_label (dist_label)
    );

    nwr_scan #(
        .ENTRIES    (ENTRIES),
        .LABEL_BITS (LABEL_BITS),
        .AW         (AW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_action      (i_action),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_entry_count (r_entry_count),
        .i_radius_sq   (r_radius_sq),
        .i_dist        (dist_word),
        .i_dist_label  (dist_label),
        .i_out_stall   (i_stall),
        .o_stall       (o_stall),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_qx          (q_x),
        .o_qy          (q_y),
        .o_out_valid   (o_valid),
        .o_found       (o_found),
        .o_label       (o_waypoint_label)
    );

    // A query holds the input side off on the next cycle.
    `ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_valid && !o_stall && i_action == nwr_pkg::ACT_QUERY, o_stall)
    // A load leaves the block ready on the next cycle.
    `ASSERT_NEXT(a_load_ready, i_clk, i_rst_n, i_valid && !o_stall && i_action == nwr_pkg::ACT_LOAD, !o_stall)
    // Table reads and distance words only appear during a query.
    `ASSERT_IMPL(a_read_in_scan, i_clk, i_rst_n, rd_en, o_stall)
    `ASSERT_IMPL(a_dist_in_scan, i_clk, i_rst_n, dist_word.valid, o_stall)

endmodule

`default_nettype wire

// File: sim/tb_top.sv
module tb_top;

    localparam int TABLE_DEPTH = nwr_pkg::DEF_ENTRIES;
    // Longest query is a scan of the full table plus its pipeline.
    localparam int SCAN_SLACK  = TABLE_DEPTH + 16;
    localparam int IDLE_LIMIT  = 4000;
    localparam int WORD_TARGET = 1200;

    typedef logic signed [nwr_pkg::COORD_BITS-1:0] t_coord;
    typedef logic [nwr_pkg::INDEX_BITS-1:0]        t_slot;
    typedef logic [nwr_pkg::LABEL_IN_BITS-1:0]     t_label;
    typedef logic [nwr_pkg::CFG_DATA_BITS-1:0]     t_cfg_data;

    typedef struct {
        logic   action;
        t_slot  slot;
        t_label label;
        t_coord x;
        t_coord y;
    } t_waypoint_word;

    typedef struct packed {
        logic   found;
        t_label label;
    } t_nearest_answer;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_BURSTS,
        STALL_PERIODIC
    } t_stall_mode;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [nwr_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    t_cfg_data                         i_cfg_data = '0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic                              i_action = nwr_pkg::ACT_LOAD;
    t_slot                             i_entry_index = '0;
    t_label                            i_entry_label = '0;
    t_coord                            i_pos_x = '0;
    t_coord                            i_pos_y = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic                              o_found;
    t_label                            o_waypoint_label;

    // Shadow copy of the waypoint table and registers.
    t_coord                            model_x [TABLE_DEPTH];
    t_coord                            model_y [TABLE_DEPTH];
    t_label                            model_label [TABLE_DEPTH];
    logic [nwr_pkg::RADIUS_BITS-1:0]   model_radius = '0;
    logic [nwr_pkg::COUNT_BITS-1:0]    model_count = '0;

    t_nearest_answer pending_answers [$];
    int              fail_count = 0;
    int              words_sent = 0;
    int              burst_left = 0;
    int              gap_max = 0;
    int              quiet_cycles = 0;
    int              stall_hold = 0;
    int              stall_phase = 0;
    t_stall_mode     stall_mode = STALL_NONE;

    nearest_waypoint_within_radius_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_entry_index    (i_entry_index),
        .i_entry_label    (i_entry_label),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_found          (o_found),
        .o_waypoint_label (o_waypoint_label)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Number of entries a query scans, with the count saturated at the table size.
    function automatic int scan_length();
        return (model_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_count);
    endfunction

    // Nearest entry by squared distance, earliest index on a tie.
    function automatic t_nearest_answer predict_nearest(input t_coord qx, input t_coord qy);
        longint          best;
        longint          d2;
        longint          dx;
        longint          dy;
        longint          r2;
        bit              have;
        t_nearest_answer ans;
        have = 1'b0;
        best = 0;
        ans  = '0;
        r2   = longint'(model_radius) * longint'(model_radius);
        for (int i = 0; i < scan_length(); i++) begin
            dx = longint'(model_x[i]) - longint'(qx);
            dy = longint'(model_y[i]) - longint'(qy);
            d2 = dx * dx + dy * dy;
            if (!have || d2 < best) begin
                have      = 1'b1;
                best      = d2;
                ans.label = model_label[i];
            end
        end
        if (have && best <= r2) begin
            ans.found = 1'b1;
        end else begin
            ans = '0;
        end
        return ans;
    endfunction

    // Coordinates half the time on a coarse grid so that ties and near hits are common.
    function automatic t_coord random_coord();
        int v;
        case ($urandom_range(0, 3))
            0, 1: begin
                v = (int'($urandom_range(0, 32)) - 16) * 64;
            end
            2: begin
                v = int'($urandom());
            end
            default: begin
                v = int'($urandom_range(0, 8192)) - 4096;
            end
        endcase
        return t_coord'(v);
    endfunction

    // Send one word in the current burst, then update the shadow table or queue a prediction on acceptance.
    task automatic send_word(input t_waypoint_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = int'($urandom_range(1, 24));
            gap = (gap_max == 0) ? 0 : int'($urandom_range(0, gap_max));
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_action      <= w.action;
        i_entry_index <= w.slot;
        i_entry_label <= w.label;
        i_pos_x       <= w.x;
        i_pos_y       <= w.y;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (w.action == nwr_pkg::ACT_LOAD) begin
            model_x[w.slot]     = w.x;
            model_y[w.slot]     = w.y;
            model_label[w.slot] = w.label;
        end else begin
            pending_answers.push_back(predict_nearest(w.x, w.y));
        end
        words_sent++;
    endtask

    task automatic send_load(input t_slot slot, input t_label label,
                             input t_coord x, input t_coord y);
        t_waypoint_word w;
        w.action = nwr_pkg::ACT_LOAD;
        w.slot   = slot;
        w.label  = label;
        w.x      = x;
        w.y      = y;
        send_word(w);
    endtask

    // Slot and label carry random values on a query since the block ignores them.
    task automatic send_query(input t_coord x, input t_coord y);
        t_waypoint_word w;
        w.action = nwr_pkg::ACT_QUERY;
        w.slot   = t_slot'($urandom_range(0, TABLE_DEPTH - 1));
        w.label  = t_label'($urandom_range(0, 255));
        w.x      = x;
        w.y      = y;
        send_word(w);
    endtask

    // Query close to a scanned entry, or anywhere now and then.
    task automatic send_near_query(input int n, input int span);
        int idx;
        int qx;
        int qy;
        if (n == 0 || $urandom_range(0, 3) == 0) begin
            send_query(random_coord(), random_coord());
        end else begin
            idx = int'($urandom_range(0, n - 1));
            qx  = int'(model_x[idx]);
            qy  = int'(model_y[idx]);
            if ($urandom_range(0, 9) != 0) begin
                qx = qx + int'($urandom_range(0, 2 * span)) - span;
                qy = qy + int'($urandom_range(0, 2 * span)) - span;
            end
            if (qx > 32767) qx = 32767;
            if (qx < -32768) qx = -32768;
            if (qy > 32767) qy = 32767;
            if (qy < -32768) qy = -32768;
            send_query(t_coord'(qx), t_coord'(qy));
        end
    endtask

    // Wait until every answer is back and any scan still running has ended.
    task automatic settle_block();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SCAN_SLACK) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [nwr_pkg::CFG_IDX_BITS-1:0] index,
                             input t_cfg_data data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (index == nwr_pkg::CFG_MATCH_RADIUS) begin
            model_radius = data[nwr_pkg::RADIUS_BITS-1:0];
        end else begin
            model_count = data[nwr_pkg::COUNT_BITS-1:0];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Both registers are rewritten in random order once the block is idle.
    task automatic program_registers(input t_cfg_data radius, input t_cfg_data count_word);
        settle_block();
        if ($urandom_range(0, 1) == 0) begin
            cfg_write(nwr_pkg::CFG_MATCH_RADIUS, radius);
            cfg_write(nwr_pkg::CFG_ENTRY_COUNT, count_word);
        end else begin
            cfg_write(nwr_pkg::CFG_ENTRY_COUNT, count_word);
            cfg_write(nwr_pkg::CFG_MATCH_RADIUS, radius);
        end
    endtask

    // An empty table never reports a match.
    task automatic test_empty_table();
        send_query(16'sh8000, 16'sh7FFF);
        send_query(16'sh0000, 16'sh0000);
    endtask

    // Extreme coordinates and labels, ties, and distances right at the radius.
    task automatic test_corner_entries();
        send_load(6'd0, 8'hFF, 16'sh8000, 16'sh8000);
        send_load(6'd1, 8'h00, 16'sh7FFF, 16'sh7FFF);
        send_load(6'd2, 8'hA5, 16'sh0000, 16'sh0000);
        send_load(6'd3, 8'h5A, 16'sh0000, 16'sh0000);
        send_load(6'd4, 8'h3C, 16'sd300, 16'sd400);
        send_load(6'd63, 8'h81, 16'sh2AAA, 16'shD555);
        program_registers(16'd500, 16'd5);
        send_query(-16'sd300, -16'sd400);
        send_query(16'sd150, 16'sd200);
        send_query(16'sd300, 16'sd400);
        send_query(16'sh8000, 16'sh8000);
        send_query(16'sh7FFF, 16'sh7FFF);
        send_query(16'sh7FFF, 16'sh8000);
        send_query(16'sd8000, -16'sd8000);
        program_registers(16'd499, 16'd5);
        send_query(-16'sd300, -16'sd400);
        send_query(16'sd150, 16'sd200);
        // The far corner sits exactly at the largest radius from two entries.
        program_registers(16'hFFFF, 16'd5);
        send_query(16'sh7FFF, 16'sh8000);
        program_registers(16'd0, 16'd5);
        send_query(16'sd300, 16'sd400);
        send_query(16'sd301, 16'sd400);
    endtask

    // Fill the whole table, then scan it with counts at and beyond its size.
    task automatic test_count_saturation();
        t_cfg_data count_words [3];
        count_words = '{16'd64, 16'd65, 16'hFFFF};
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            send_load(t_slot'(s), t_label'($urandom_range(0, 255)),
                      random_coord(), random_coord());
        end
        foreach (count_words[k]) begin
            program_registers(t_cfg_data'($urandom_range(64, 2048)), count_words[k]);
            repeat (12) send_near_query(scan_length(), int'(model_radius) + 32);
        end
    endtask

    // Phases of mixed loads and queries under varying settings and flow control.
    task automatic test_random_traffic();
        int        n;
        int        span;
        t_cfg_data radius;
        t_cfg_data count_word;
        while (words_sent < WORD_TARGET) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: gap_max = 0;
                1: gap_max = 2;
                2: gap_max = 8;
                default: gap_max = 20;
            endcase
            case ($urandom_range(0, 9))
                0: radius = '0;
                1: radius = 16'hFFFF;
                2: radius = t_cfg_data'($urandom_range(0, 16'hFFFF));
                default: radius = t_cfg_data'($urandom_range(1, 1500));
            endcase
            case ($urandom_range(0, 9))
                0: count_word = 16'd0;
                1: count_word = 16'd64;
                2: count_word = t_cfg_data'($urandom_range(65, 127));
                3: count_word = 16'd1;
                default: count_word = t_cfg_data'($urandom_range(2, 40));
            endcase
            program_registers(radius, count_word);
            n    = scan_length();
            span = int'(model_radius) + 32;
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_load(t_slot'($urandom_range(0, TABLE_DEPTH - 1)),
                              t_label'($urandom_range(0, 255)),
                              random_coord(), random_coord());
                end else begin
                    send_near_query(n, span);
                end
            end
        end
    endtask

    // Receiver flow control on a pattern chosen per phase.
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase == 4) ? 0 : stall_phase + 1;
        case (stall_mode)
            STALL_NONE: begin
                i_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_BURSTS: begin
                if (stall_hold != 0) begin
                    stall_hold <= stall_hold - 1;
                    i_stall    <= 1'b1;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_hold <= int'($urandom_range(1, 40));
                    i_stall    <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
            default: begin
                i_stall <= (stall_phase < 2);
            end
        endcase
    end

    task automatic note_mismatch(input string what, input t_nearest_answer want);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s: expected found=%0b label=%02h, got found=%0b label=%02h",
                     $realtime, what, want.found, want.label, o_found, o_waypoint_label);
        end
    endtask

    // Each accepted answer is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_answers
        t_nearest_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                note_mismatch("answer with none pending", '0);
            end else begin
                want = pending_answers.pop_front();
                if (o_found !== want.found || o_waypoint_label !== want.label) begin
                    note_mismatch("wrong answer", want);
                end
            end
        end
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_corner_entries();
        test_count_saturation();
        test_random_traffic();
        settle_block();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
